// ===== design/oale_pkg.sv =====
// Package for the ordered array list engine.
// Holds request and status codes, the sequencer state type and the check result struct.
// No dependencies.
package oale_pkg;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_GET    = 3'd1,
        REQ_LOCATE = 3'd2,
        REQ_PRIOR  = 3'd3,
        REQ_NEXT   = 3'd4,
        REQ_INSERT = 3'd5,
        REQ_DELETE = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BADPOS   = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_DOWN = 7'b0000100,
        ST_UP   = 7'b0001000,
        ST_PUT  = 7'b0010000,
        ST_GRAB = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic bad_pos;
        logic full;
    } chk_t;

endpackage

// ===== design/oale_check.sv =====
// Position and capacity check for an incoming request.
// Depends on oale_pkg (req_t, chk_t).
module oale_check import oale_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic [2:0]                        req_type,
    input  logic [8:0]                        position,
    input  logic [$clog2(CAPACITY + 1) - 1:0] count,
    output chk_t                              chk
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 9) ? CW : 9) + 1;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;

    assign pos_w = PW'(position);
    assign cnt_w = PW'(count);

    always_comb
    begin
        chk = '0;
        unique case (req_t'(req_type))
            REQ_GET, REQ_DELETE:
            begin
                chk.bad_pos = (pos_w == '0) || (pos_w > cnt_w);
            end
            REQ_INSERT:
            begin
                chk.bad_pos = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
                chk.full    = !chk.bad_pos && (cnt_w >= PW'(CAPACITY));
            end
            default:
            begin
                chk = '0;
            end
        endcase
    end

endmodule

// ===== design/ordered_array_list_engine_unit.sv =====
// Top level of the ordered array list engine: sequencer around one list memory.
// Depends on oale_pkg and oale_check.
//
// The list lives in a CAPACITY-deep memory with one read and one write port and a
// registered read; the element count sits in a register, so no clearing pass
// runs after reset. One request is worked on at a time; the next one is taken while
// the previous result still waits on the output register. Clear, an unknown request
// and a rejected request go straight to the result; get reads its one element.
// Locate, prior and next walk the list one element per cycle; next then fetches
// the successor in a further state. Insert at position p moves the elements from the
// end down to p up by one place and then writes the value; when it appends at the
// end it writes at once. Delete at position p moves the elements behind p down by
// one place. The pace of the walks is set by the single memory read port, which
// delivers one element per cycle.
module ordered_array_list_engine_unit import oale_pkg::*; #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [8:0]  position,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] result_value,
    output logic [8:0]  result_position,
    output logic [8:0]  count,
    output logic        is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 9) ? CW : 9) + 1;
    localparam int VW = VALUE_WIDTH;

    logic [VW-1:0]  list_mem [CAPACITY];
    logic [VW-1:0]  rd_data_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [CW-1:0]  pos0_reg, pos0_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           more_reg, more_next;
    logic           pend_reg, pend_next;
    logic [CW-1:0]  kd_reg, kd_next;
    logic [VW-1:0]  prev_reg, prev_next;
    status_t        op_status_reg, op_status_next;
    logic [VW-1:0]  rval_reg, rval_next;
    logic [CW-1:0]  rpos_reg, rpos_next;

    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_status_reg, out_status_next;
    logic [31:0]    out_value_reg, out_value_next;
    logic [8:0]     out_pos_reg, out_pos_next;
    logic [8:0]     out_count_reg, out_count_next;
    logic           out_empty_reg, out_empty_next;

    chk_t           chk;
    logic [PW-1:0]  pos_wide;
    logic [CW-1:0]  pos0_in;
    logic [VW+31:0] val_in_ext;
    logic [VW-1:0]  val_in;
    logic [VW+31:0] rval_ext;
    logic [CW+8:0]  cnt_ext;
    logic [CW+8:0]  rpos_ext;
    logic [CW-1:0]  cnt_last;
    logic [CW-1:0]  kd_dn;
    logic [CW-1:0]  kd_up;
    logic           hit;

    oale_check #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .req_type (req_type),
        .position (position),
        .count    (cnt_reg),
        .chk      (chk)
    );

    assign pos_wide   = PW'(position) - PW'(1);
    assign pos0_in    = pos_wide[CW-1:0];
    assign val_in_ext = {{VW{1'b0}}, value};
    assign val_in     = val_in_ext[VW-1:0];
    assign rval_ext   = {32'b0, rval_reg};
    assign cnt_ext    = {9'b0, cnt_reg};
    assign rpos_ext   = {9'b0, rpos_reg};
    assign cnt_last   = cnt_reg - CW'(1);
    assign kd_dn      = kd_reg - CW'(1);
    assign kd_up      = kd_reg + CW'(1);
    assign hit        = (rd_data_reg == val_reg);
    assign rd_addr    = idx_reg[AW-1:0];

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_value    = out_value_reg;
    assign result_position = out_pos_reg;
    assign count           = out_count_reg;
    assign is_empty        = out_empty_reg;

    // list memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        pos0_next       = pos0_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        more_next       = more_reg;
        pend_next       = pend_reg;
        kd_next         = kd_reg;
        prev_next       = prev_reg;
        op_status_next  = op_status_reg;
        rval_next       = rval_reg;
        rpos_next       = rpos_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = val_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = req_t'(req_type);
                    val_next       = val_in;
                    pos0_next      = pos0_in;
                    op_status_next = STAT_OK;
                    rval_next      = '0;
                    rpos_next      = '0;
                    more_next      = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = ST_DONE;
                    case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        REQ_GET, REQ_DELETE:
                        begin
                            if (chk.bad_pos)
                            begin
                                op_status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                idx_next   = pos0_in;
                                state_next = ST_DOWN;
                            end
                        end
                        REQ_LOCATE, REQ_PRIOR, REQ_NEXT:
                        begin
                            op_status_next = STAT_NOTFOUND;
                            if (cnt_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (chk.bad_pos)
                            begin
                                op_status_next = STAT_BADPOS;
                            end
                            else if (chk.full)
                            begin
                                op_status_next = STAT_FULL;
                            end
                            else if (pos0_in == cnt_reg)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                idx_next   = cnt_last;
                                state_next = ST_UP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (more_reg)
                begin
                    rd_en     = 1'b1;
                    kd_next   = idx_reg;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    if (idx_reg == cnt_last)
                    begin
                        more_next = 1'b0;
                    end
                end
                if (pend_reg)
                begin
                    prev_next = rd_data_reg;
                    if (req_reg == REQ_LOCATE && hit)
                    begin
                        rpos_next      = kd_up;
                        op_status_next = STAT_OK;
                        state_next     = ST_DONE;
                    end
                    else if (req_reg == REQ_PRIOR && hit && kd_reg != '0)
                    begin
                        rval_next      = prev_reg;
                        op_status_next = STAT_OK;
                        state_next     = ST_DONE;
                    end
                    else if (req_reg == REQ_NEXT && hit && kd_reg != cnt_last)
                    begin
                        op_status_next = STAT_OK;
                        state_next     = ST_GRAB;
                    end
                    else if (kd_reg == cnt_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DOWN:
            begin
                pend_next = 1'b0;
                if (more_reg)
                begin
                    rd_en     = 1'b1;
                    kd_next   = idx_reg;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    if (idx_reg == cnt_last || req_reg == REQ_GET)
                    begin
                        more_next = 1'b0;
                    end
                end
                if (pend_reg)
                begin
                    if (kd_reg == pos0_reg)
                    begin
                        rval_next = rd_data_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = kd_dn[AW-1:0];
                        wr_data = rd_data_reg;
                    end
                    if (req_reg == REQ_GET)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (kd_reg == cnt_last)
                    begin
                        cnt_next   = cnt_last;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_UP:
            begin
                pend_next = 1'b0;
                if (more_reg)
                begin
                    rd_en     = 1'b1;
                    kd_next   = idx_reg;
                    pend_next = 1'b1;
                    idx_next  = idx_reg - CW'(1);
                    if (idx_reg == pos0_reg)
                    begin
                        more_next = 1'b0;
                    end
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = kd_up[AW-1:0];
                    wr_data = rd_data_reg;
                    if (kd_reg == pos0_reg)
                    begin
                        state_next = ST_PUT;
                    end
                end
            end

            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos0_reg[AW-1:0];
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_DONE;
            end

            ST_GRAB:
            begin
                rval_next  = rd_data_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = op_status_reg;
                    out_value_next  = rval_ext[31:0];
                    out_pos_next    = rpos_ext[8:0];
                    out_count_next  = cnt_ext[8:0];
                    out_empty_next  = (cnt_reg == '0);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        pos0_reg       <= pos0_next;
        idx_reg        <= idx_next;
        kd_reg         <= kd_next;
        prev_reg       <= prev_next;
        op_status_reg  <= op_status_next;
        rval_reg       <= rval_next;
        rpos_reg       <= rpos_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

endmodule
